// File: rtl/console_line_editor_unit_defines.svh
// assertion macros for the console line editor
`ifndef CONSOLE_LINE_EDITOR_UNIT_DEFINES_SVH
`define CONSOLE_LINE_EDITOR_UNIT_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define CLE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define CLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/cle_pkg.sv
// shared constants and result type of the console line editor
package cle_pkg;

    localparam int CLE_BUF_DEPTH = 128;

    localparam logic [7:0] CH_EOF  = 8'h04;
    localparam logic [7:0] CH_KILL = 8'h15;
    localparam logic [7:0] CH_BS   = 8'h08;
    localparam logic [7:0] CH_LIST = 8'h10;
    localparam logic [7:0] CH_DEL  = 8'h7F;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_NUL  = 8'h00;

    localparam logic MODE_RX   = 1'b0;
    localparam logic MODE_READ = 1'b1;

    localparam logic [1:0] RD_EMPTY = 2'd0;
    localparam logic [1:0] RD_BYTE  = 2'd1;
    localparam logic [1:0] RD_LINE  = 2'd2;
    localparam logic [1:0] RD_EOF   = 2'd3;

    typedef struct packed {
        logic       echo_valid;
        logic [7:0] echo_byte;
        logic [7:0] erase_count;
        logic       line_ready;
        logic       list_request;
        logic [1:0] read_status;
        logic [7:0] read_byte;
    } cle_result_t;

endpackage

// File: rtl/cle_line_ram.sv
// line store: one write port, one registered read port
module cle_line_ram import cle_pkg::*; #(
    parameter int DEPTH  = CLE_BUF_DEPTH,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/cle_ctrl.sv
// sequencer: decodes one item, keeps the ring positions, walks back on kill
module cle_ctrl import cle_pkg::*; #(
    parameter int BUF_DEPTH = CLE_BUF_DEPTH,
    parameter int IDX_W     = $clog2(BUF_DEPTH)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_mode,
    input  logic [7:0]       in_byte,
    input  logic             in_first,
    output logic             res_valid,
    input  logic             res_ready,
    output cle_result_t      res,
    output logic             mem_wr_en,
    output logic [IDX_W-1:0] mem_wr_addr,
    output logic [7:0]       mem_wr_data,
    output logic             mem_rd_en,
    output logic [IDX_W-1:0] mem_rd_addr,
    input  logic [7:0]       mem_rd_data
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUF_DEPTH - 1);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_DECODE    = 3'd1;
    localparam logic [2:0] ST_RD_WAIT   = 3'd2;
    localparam logic [2:0] ST_KILL_CHK  = 3'd3;
    localparam logic [2:0] ST_KILL_WAIT = 3'd4;
    localparam logic [2:0] ST_DONE      = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             rd_wrap_reg, rd_wrap_next;
    logic [IDX_W-1:0] cm_idx_reg, cm_idx_next;
    logic             cm_wrap_reg, cm_wrap_next;
    logic [IDX_W-1:0] ed_idx_reg, ed_idx_next;
    logic             ed_wrap_reg, ed_wrap_next;
    cle_result_t      res_reg, res_next;

    logic             mode_reg;
    logic [7:0]       byte_reg;
    logic             first_reg;

    logic             accept;
    logic [IDX_W-1:0] ed_inc_idx, ed_dec_idx, rd_inc_idx;
    logic             ed_inc_wrap, ed_dec_wrap, rd_inc_wrap;
    logic             store_full, full_after, has_uncommitted, has_committed;
    logic [7:0]       rx_mapped;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);

    // ring position arithmetic: slot index plus a wrap bit
    assign ed_inc_idx  = (ed_idx_reg == LAST_IDX) ? '0 : ed_idx_reg + 1'b1;
    assign ed_inc_wrap = (ed_idx_reg == LAST_IDX) ? ~ed_wrap_reg : ed_wrap_reg;
    assign ed_dec_idx  = (ed_idx_reg == '0) ? LAST_IDX : ed_idx_reg - 1'b1;
    assign ed_dec_wrap = (ed_idx_reg == '0) ? ~ed_wrap_reg : ed_wrap_reg;
    assign rd_inc_idx  = (rd_idx_reg == LAST_IDX) ? '0 : rd_idx_reg + 1'b1;
    assign rd_inc_wrap = (rd_idx_reg == LAST_IDX) ? ~rd_wrap_reg : rd_wrap_reg;

    assign store_full      = (ed_idx_reg == rd_idx_reg) && (ed_wrap_reg != rd_wrap_reg);
    assign full_after      = (ed_inc_idx == rd_idx_reg) && (ed_inc_wrap != rd_wrap_reg);
    assign has_uncommitted = (ed_idx_reg != cm_idx_reg) || (ed_wrap_reg != cm_wrap_reg);
    assign has_committed   = (rd_idx_reg != cm_idx_reg) || (rd_wrap_reg != cm_wrap_reg);
    assign rx_mapped       = (byte_reg == CH_CR) ? CH_NL : byte_reg;

    always_comb begin
        state_next   = state_reg;
        rd_idx_next  = rd_idx_reg;
        rd_wrap_next = rd_wrap_reg;
        cm_idx_next  = cm_idx_reg;
        cm_wrap_next = cm_wrap_reg;
        ed_idx_next  = ed_idx_reg;
        ed_wrap_next = ed_wrap_reg;
        res_next     = res_reg;
        mem_wr_en    = 1'b0;
        mem_wr_addr  = ed_idx_reg;
        mem_wr_data  = rx_mapped;
        mem_rd_en    = 1'b0;
        mem_rd_addr  = rd_idx_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                res_next   = '0;
                state_next = ST_DONE;
                if (mode_reg == MODE_READ) begin
                    if (has_committed) begin
                        mem_rd_en  = 1'b1;
                        state_next = ST_RD_WAIT;
                    end
                end else if (byte_reg == CH_LIST) begin
                    res_next.list_request = 1'b1;
                end else if (byte_reg == CH_KILL) begin
                    state_next = ST_KILL_CHK;
                end else if (byte_reg == CH_BS || byte_reg == CH_DEL) begin
                    if (has_uncommitted) begin
                        ed_idx_next          = ed_dec_idx;
                        ed_wrap_next         = ed_dec_wrap;
                        res_next.erase_count = 8'd1;
                    end
                end else if (byte_reg != CH_NUL && !store_full) begin
                    mem_wr_en           = 1'b1;
                    res_next.echo_valid = 1'b1;
                    res_next.echo_byte  = rx_mapped;
                    ed_idx_next         = ed_inc_idx;
                    ed_wrap_next        = ed_inc_wrap;
                    if (rx_mapped == CH_NL || rx_mapped == CH_EOF || full_after) begin
                        cm_idx_next         = ed_inc_idx;
                        cm_wrap_next        = ed_inc_wrap;
                        res_next.line_ready = 1'b1;
                    end
                end
            end
            ST_RD_WAIT: begin
                state_next = ST_DONE;
                if (mem_rd_data == CH_EOF) begin
                    res_next.read_status = RD_EOF;
                    if (first_reg) begin
                        rd_idx_next  = rd_inc_idx;
                        rd_wrap_next = rd_inc_wrap;
                    end
                end else begin
                    rd_idx_next          = rd_inc_idx;
                    rd_wrap_next         = rd_inc_wrap;
                    res_next.read_byte   = mem_rd_data;
                    res_next.read_status = (mem_rd_data == CH_NL) ? RD_LINE : RD_BYTE;
                end
            end
            ST_KILL_CHK: begin
                if (has_uncommitted) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = ed_dec_idx;
                    state_next  = ST_KILL_WAIT;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_KILL_WAIT: begin
                if (mem_rd_data != CH_NL) begin
                    ed_idx_next  = ed_dec_idx;
                    ed_wrap_next = ed_dec_wrap;
                    // count saturates at 255
                    if (res_reg.erase_count != 8'hFF) begin
                        res_next.erase_count = res_reg.erase_count + 8'd1;
                    end
                    state_next = ST_KILL_CHK;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rd_idx_reg  <= '0;
            rd_wrap_reg <= 1'b0;
            cm_idx_reg  <= '0;
            cm_wrap_reg <= 1'b0;
            ed_idx_reg  <= '0;
            ed_wrap_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rd_idx_reg  <= rd_idx_next;
            rd_wrap_reg <= rd_wrap_next;
            cm_idx_reg  <= cm_idx_next;
            cm_wrap_reg <= cm_wrap_next;
            ed_idx_reg  <= ed_idx_next;
            ed_wrap_reg <= ed_wrap_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        if (accept) begin
            mode_reg  <= in_mode;
            byte_reg  <= in_byte;
            first_reg <= in_first;
        end
    end

    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

endmodule

// File: rtl/console_line_editor_unit.sv
// console line editor top level: sequencer, line store and result register
// a received byte passes the decode state, a read adds a wait for the store read, and a
// control-U passes kill check and kill wait for each erased byte (up to BUF_DEPTH - 1)
// one item at a time: a new item is taken only after the sequencer hands its result to
// the result register; each step of the kill walk reads the store through its registered port
// synchronous active-low reset zeroes read, commit and edit positions; store contents
// stay undefined until written and need no clearing pass
`include "console_line_editor_unit_defines.svh"

module console_line_editor_unit import cle_pkg::*; #(
    parameter int BUF_DEPTH = CLE_BUF_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_mode,
    input  logic [7:0] s_rx_byte,
    input  logic       s_first_of_read,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_echo_valid,
    output logic [7:0] m_echo_byte,
    output logic [7:0] m_erase_count,
    output logic       m_line_ready,
    output logic       m_list_request,
    output logic [1:0] m_read_status,
    output logic [7:0] m_read_byte
);

    localparam int IDX_W = $clog2(BUF_DEPTH);

    logic             res_valid;
    logic             res_ready;
    cle_result_t      res;
    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    logic [7:0]       mem_wr_data;
    logic             mem_rd_en;
    logic [IDX_W-1:0] mem_rd_addr;
    logic [7:0]       mem_rd_data;

    logic             m_valid_reg;
    cle_result_t      out_reg;

    cle_ctrl #(
        .BUF_DEPTH (BUF_DEPTH),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_mode     (s_mode),
        .in_byte     (s_rx_byte),
        .in_first    (s_first_of_read),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    cle_line_ram #(
        .DEPTH  (BUF_DEPTH),
        .ADDR_W (IDX_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // result register frees the sequencer while the consumer stalls
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_echo_valid   = out_reg.echo_valid;
    assign m_echo_byte    = out_reg.echo_byte;
    assign m_erase_count  = out_reg.erase_count;
    assign m_line_ready   = out_reg.line_ready;
    assign m_list_request = out_reg.list_request;
    assign m_read_status  = out_reg.read_status;
    assign m_read_byte    = out_reg.read_byte;

    `CLE_ASSERT_NEXT(a_result_loaded, aclk, aresetn, res_valid && res_ready, m_valid_reg, "finished result not registered")
    `CLE_ASSERT_NEXT(a_one_item, aclk, aresetn, s_valid && s_ready, !s_ready, "second transfer taken while an item is in work")
    `CLE_ASSERT_NOW(a_read_exclusive, aclk, aresetn, m_valid_reg && (m_read_status != RD_EMPTY), !m_echo_valid && !m_list_request && (m_erase_count == 8'd0), "read result mixed with receive fields")
    `CLE_ASSERT_NOW(a_commit_on_append, aclk, aresetn, m_valid_reg && m_line_ready, m_echo_valid, "line committed without an appended byte")
    `CLE_ASSERT_NOW(a_no_write_on_read, aclk, aresetn, mem_wr_en, !mem_rd_en, "store written and read in the same cycle")

endmodule

// File: bench/console_line_editor_unit_test.sv
// self-checking testbench for the console line editor: typed edits, kills, reads and eof
`timescale 1ns / 1ps

module console_line_editor_unit_test;
    import cle_pkg::*;

    localparam int SPAN = 2 * CLE_BUF_DEPTH;
    localparam int ITEM_TARGET = 1950;
    localparam int IDLE_PCT = 24;

    logic       aclk;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_mode = MODE_RX;
    logic [7:0] s_rx_byte = CH_NUL;
    logic       s_first_of_read = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_echo_valid;
    logic [7:0] m_echo_byte;
    logic [7:0] m_erase_count;
    logic       m_line_ready;
    logic       m_list_request;
    logic [1:0] m_read_status;
    logic [7:0] m_read_byte;

    // predicted editor state
    logic [7:0]  line_mem [CLE_BUF_DEPTH];
    int          rd_pos = 0;
    int          cm_pos = 0;
    int          ed_pos = 0;
    cle_result_t outcome_q [$];

    int items_sent = 0;
    int mismatches = 0;
    bit idle_on = 1'b1;

    console_line_editor_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_rx_byte      (s_rx_byte),
        .s_first_of_read(s_first_of_read),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_echo_valid   (m_echo_valid),
        .m_echo_byte    (m_echo_byte),
        .m_erase_count  (m_erase_count),
        .m_line_ready   (m_line_ready),
        .m_list_request (m_list_request),
        .m_read_status  (m_read_status),
        .m_read_byte    (m_read_byte)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("console_line_editor_unit_test: done, errors");
        $finish;
    end

    function automatic int store_fill();
        return (ed_pos + SPAN - rd_pos) % SPAN;
    endfunction

    function automatic int pos_back(int p);
        return (p + SPAN - 1) % SPAN;
    endfunction

    // one step of the line discipline on the predicted state
    function automatic cle_result_t line_edit_outcome(logic mode, logic [7:0] ch, logic first);
        cle_result_t r;
        logic [7:0]  c;
        int          n;
        r = '0;
        c = ch;
        n = 0;
        if (mode == MODE_READ) begin
            if (rd_pos != cm_pos) begin
                c = line_mem[rd_pos % CLE_BUF_DEPTH];
                if (c == CH_EOF) begin
                    r.read_status = RD_EOF;
                    // eof mark stays for the next read unless it opens this one
                    if (first)
                        rd_pos = (rd_pos + 1) % SPAN;
                end else begin
                    rd_pos = (rd_pos + 1) % SPAN;
                    r.read_byte = c;
                    r.read_status = (c == CH_NL) ? RD_LINE : RD_BYTE;
                end
            end
        end else if (c == CH_LIST) begin
            r.list_request = 1'b1;
        end else if (c == CH_KILL) begin
            while (ed_pos != cm_pos && line_mem[pos_back(ed_pos) % CLE_BUF_DEPTH] != CH_NL) begin
                ed_pos = pos_back(ed_pos);
                n++;
            end
            r.erase_count = (n > 255) ? 8'd255 : 8'(n);
        end else if (c == CH_BS || c == CH_DEL) begin
            if (ed_pos != cm_pos) begin
                ed_pos = pos_back(ed_pos);
                r.erase_count = 8'd1;
            end
        end else if (c != CH_NUL && store_fill() < CLE_BUF_DEPTH) begin
            if (c == CH_CR)
                c = CH_NL;
            r.echo_valid = 1'b1;
            r.echo_byte = c;
            line_mem[ed_pos % CLE_BUF_DEPTH] = c;
            ed_pos = (ed_pos + 1) % SPAN;
            if (c == CH_NL || c == CH_EOF || store_fill() == CLE_BUF_DEPTH) begin
                cm_pos = ed_pos;
                r.line_ready = 1'b1;
            end
        end
        return r;
    endfunction

    // entered and left at a falling edge
    task automatic send_item(input logic mode, input logic [7:0] ch, input logic first);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= mode;
        s_rx_byte <= ch;
        s_first_of_read <= first;
        do
            @(posedge aclk);
        while (!s_ready);
        outcome_q.push_back(line_edit_outcome(mode, ch, first));
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_key(input logic [7:0] ch);
        send_item(MODE_RX, ch, 1'($urandom_range(1)));
    endtask

    task automatic send_read(input logic first);
        send_item(MODE_READ, 8'($urandom_range(255)), first);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (outcome_q.size() != 0)
            @(negedge aclk);
    endtask

    task automatic read_until_empty();
        while (rd_pos != cm_pos)
            send_read(1'b1);
    endtask

    task automatic test_basic_editing();
        send_item(MODE_RX, CH_NUL, 1'b0);
        send_item(MODE_RX, CH_LIST, 1'b1);
        send_item(MODE_READ, 8'hFF, 1'b1);     // nothing committed yet
        send_item(MODE_RX, CH_BS, 1'b0);       // erase with nothing pending
        send_item(MODE_RX, 8'h61, 1'b0);
        send_item(MODE_RX, 8'hFF, 1'b1);
        send_item(MODE_RX, 8'h80, 1'b0);
        send_item(MODE_RX, CH_DEL, 1'b0);
        send_item(MODE_RX, CH_KILL, 1'b0);
        send_item(MODE_RX, 8'h68, 1'b0);
        send_item(MODE_RX, 8'h69, 1'b0);
        send_item(MODE_RX, CH_CR, 1'b0);       // cr maps to newline and commits
        send_item(MODE_READ, 8'h00, 1'b1);
        send_item(MODE_READ, 8'hFF, 1'b0);
        send_item(MODE_READ, 8'h00, 1'b0);
        send_item(MODE_READ, 8'h00, 1'b1);
        send_item(MODE_RX, 8'h78, 1'b0);
        send_item(MODE_RX, CH_EOF, 1'b0);
        send_item(MODE_RX, CH_BS, 1'b0);       // committed bytes cannot be erased
        send_item(MODE_READ, 8'h00, 1'b1);
        send_item(MODE_READ, 8'h00, 1'b0);     // eof left in place
        send_item(MODE_READ, 8'h00, 1'b0);
        send_item(MODE_READ, 8'h00, 1'b1);     // eof consumed
        send_item(MODE_RX, CH_NL, 1'b1);
        send_item(MODE_READ, 8'h55, 1'b1);
    endtask

    task automatic test_full_store();
        read_until_empty();
        repeat (CLE_BUF_DEPTH + 2)
            send_key(8'($urandom_range(8'h20, 8'h7E)));
        send_key(CH_BS);
        send_key(CH_KILL);
        read_until_empty();
        send_read(1'b1);
        wait_drained();
    endtask

    task automatic test_long_kill();
        read_until_empty();
        repeat (CLE_BUF_DEPTH - 1)
            send_key(8'($urandom_range(8'h20, 8'h7E)));
        send_key(CH_KILL);
        send_key(8'h61);
        send_key(8'h62);
        send_key(CH_NL);
        send_key(8'h63);
        send_key(8'h64);
        send_key(CH_KILL);                     // stops at the committed newline
        read_until_empty();
    endtask

    task automatic test_random_sessions();
        int          kind;
        int          len;
        int          quiet_from;
        int          pick;
        logic [7:0]  key;
        quiet_from = items_sent + 600;
        while (items_sent < ITEM_TARGET) begin
            idle_on = !(items_sent >= quiet_from && items_sent < quiet_from + 300);
            kind = $urandom_range(99);
            if (kind < 55) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(20);
                repeat (len) begin
                    pick = $urandom_range(99);
                    if (pick < 70)
                        key = 8'($urandom_range(8'h20, 8'h7E));
                    else if (pick < 78)
                        key = $urandom_range(1) ? CH_BS : CH_DEL;
                    else if (pick < 81)
                        key = CH_KILL;
                    else if (pick < 84)
                        key = CH_LIST;
                    else if (pick < 86)
                        key = CH_NUL;
                    else
                        key = 8'($urandom_range(255));
                    send_key(key);
                end
                pick = $urandom_range(9);
                if (pick < 3)
                    send_key(CH_CR);
                else if (pick < 6)
                    send_key(CH_NL);
                else if (pick < 8)
                    send_key(CH_EOF);
            end else if (kind < 88) begin
                len = $urandom_range(1, 20);
                for (int i = 0; i < len; i++)
                    send_read((i == 0) ? 1'b1 : 1'($urandom_range(9) == 0));
            end else if (kind < 93) begin
                while (store_fill() < CLE_BUF_DEPTH)
                    send_key(8'($urandom_range(8'h20, 8'h7E)));
                repeat ($urandom_range(1, 3))
                    send_key(8'($urandom_range(255)));
            end else if (kind < 97) begin
                send_item(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)));
            end else begin
                wait_drained();
            end
        end
        idle_on = 1'b1;
    endtask

    always @(negedge aclk)
        m_ready <= idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;

    // compare every result transfer with the oldest prediction
    always @(posedge aclk) begin
        cle_result_t seen;
        cle_result_t want;
        if (aresetn && m_valid && m_ready) begin
            seen = {m_echo_valid, m_echo_byte, m_erase_count, m_line_ready,
                    m_list_request, m_read_status, m_read_byte};
            if (outcome_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: echo %0b/%h erase %0d ready %0b list %0b rd %0d/%h",
                             seen.echo_valid, seen.echo_byte, seen.erase_count,
                             seen.line_ready, seen.list_request, seen.read_status,
                             seen.read_byte);
            end else begin
                want = outcome_q.pop_front();
                if (seen.echo_valid !== want.echo_valid || seen.echo_byte !== want.echo_byte ||
                    seen.erase_count !== want.erase_count ||
                    seen.line_ready !== want.line_ready ||
                    seen.list_request !== want.list_request ||
                    seen.read_status !== want.read_status ||
                    seen.read_byte !== want.read_byte) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at %0t: expected echo %0b/%h erase %0d ready %0b list %0b rd %0d/%h",
                                 $realtime, want.echo_valid, want.echo_byte, want.erase_count,
                                 want.line_ready, want.list_request, want.read_status,
                                 want.read_byte);
                        $display("                 actual   echo %0b/%h erase %0d ready %0b list %0b rd %0d/%h",
                                 seen.echo_valid, seen.echo_byte, seen.erase_count,
                                 seen.line_ready, seen.list_request, seen.read_status,
                                 seen.read_byte);
                    end
                end
            end
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_basic_editing();
        test_full_store();
        test_long_kill();
        test_random_sessions();
        wait_drained();
        repeat (2 * CLE_BUF_DEPTH + 40) @(posedge aclk);
        if (mismatches == 0 && outcome_q.size() == 0)
            $display("console_line_editor_unit_test: done, clean");
        else
            $display("console_line_editor_unit_test: done, errors");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/cle_pkg.sv
rtl/cle_line_ram.sv
rtl/cle_ctrl.sv
rtl/console_line_editor_unit.sv
bench/console_line_editor_unit_test.sv
